// File: hdl/rdc_pkg.sv
package rdc_pkg;

  localparam int VALUE_BITS  = 31;
  localparam int STACK_DEPTH = 32;
  localparam int DIGIT_W     = 6;
  localparam int CHAR_W      = 7;
  localparam int STACK_AW    = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int BIT_CNT_W   = $clog2(VALUE_BITS);

  localparam logic [DIGIT_W-1:0] RADIX_RESET = DIGIT_W'(10);
  localparam logic [DIGIT_W-1:0] RADIX_MIN   = DIGIT_W'(2);
  localparam logic [DIGIT_W-1:0] RADIX_MAX   = DIGIT_W'(36);
  localparam logic [DIGIT_W-1:0] DEC_LIMIT   = DIGIT_W'(10);
  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]  CHAR_ALPHA  = CHAR_W'(55);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_REM_PUSH,
    ST_POP_RD,
    ST_EMIT
  } state_t;

  function automatic logic [DIGIT_W-1:0] radix_in_use(input logic [DIGIT_W-1:0] r);
    logic [DIGIT_W-1:0] res;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end else begin
      res = r;
    end
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d < DEC_LIMIT) begin
      res = CHAR_W'(d) + CHAR_ZERO;
    end else begin
      res = CHAR_W'(d) + CHAR_ALPHA;
    end
    return res;
  endfunction

endpackage

// File: hdl/radix_digit_converter_unit.sv
// channel  | handshake           | payload
// ---------+---------------------+------------------------------------------
// input    | start, busy         | value
// config   | radix_wr_en         | radix_wr_data
// result   | digit_strobe        | digit_value, digit_char, last_digit
//
// while a word is in work, busy stays high through one check per digit, a
// restoring division on the shared subtract/compare unit per digit but the
// top one, a push per remainder, and for each digit a read of the stack
// memory and a state that shows the result
// rst is synchronous; it clears the sequencer and sets radix to ten
// each result stands for one cycle only; the receiver cannot stall it
module radix_digit_converter_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [rdc_pkg::VALUE_BITS-1:0] value,
  input  logic                          radix_wr_en,
  input  logic [rdc_pkg::DIGIT_W-1:0]    radix_wr_data,
  output logic                          digit_strobe,
  output logic [rdc_pkg::DIGIT_W-1:0]    digit_value,
  output logic [rdc_pkg::CHAR_W-1:0]     digit_char,
  output logic                          last_digit
);
  import rdc_pkg::*;

  state_t                 state, state_next;
  logic [DIGIT_W-1:0]     radix;
  logic [DIGIT_W-1:0]     base, base_next;
  logic [VALUE_BITS-1:0]  quot, quot_next;
  logic [DIGIT_W-1:0]     rem, rem_next;
  logic [BIT_CNT_W-1:0]   bit_cnt, bit_cnt_next;
  logic [CNT_W-1:0]       cnt, cnt_next;
  logic [CNT_W-1:0]       cnt_dec;

  logic                   push_en;
  logic [DIGIT_W-1:0]     push_data;
  logic                   rd_en;
  logic [DIGIT_W-1:0]     rd_data;
  logic [DIGIT_W-1:0]     stack_mem [STACK_DEPTH];

  logic [DIGIT_W:0]       trial;
  logic [DIGIT_W:0]       trial_diff;
  logic                   trial_ge;
  logic                   stack_room;

  // shared subtract/compare unit
  assign trial      = {rem, quot[VALUE_BITS-1]};
  assign trial_diff = trial - {1'b0, base};
  assign trial_ge   = trial >= {1'b0, base};
  assign stack_room = cnt < CNT_W'(STACK_DEPTH);
  assign cnt_dec    = cnt - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (radix_wr_en) begin
      radix <= radix_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    base    <= base_next;
    quot    <= quot_next;
    rem     <= rem_next;
    bit_cnt <= bit_cnt_next;
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      stack_mem[cnt[STACK_AW-1:0]] <= push_data;
    end
    if (rd_en) begin
      rd_data <= stack_mem[cnt_dec[STACK_AW-1:0]];
    end
  end

  always_comb begin
    state_next   = state;
    base_next    = base;
    quot_next    = quot;
    rem_next     = rem;
    bit_cnt_next = bit_cnt;
    cnt_next     = cnt;
    push_en      = 1'b0;
    push_data    = rem;
    rd_en        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          base_next  = radix_in_use(radix);
          quot_next  = value;
          cnt_next   = '0;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (quot < {{(VALUE_BITS-DIGIT_W){1'b0}}, base}) begin
          // top digit
          push_data  = quot[DIGIT_W-1:0];
          push_en    = stack_room;
          if (stack_room) begin
            cnt_next = cnt + CNT_W'(1);
          end
          state_next = ST_POP_RD;
        end else begin
          rem_next     = '0;
          bit_cnt_next = BIT_CNT_W'(VALUE_BITS - 1);
          state_next   = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_next     = trial_ge ? trial_diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
        quot_next    = {quot[VALUE_BITS-2:0], trial_ge};
        bit_cnt_next = bit_cnt - BIT_CNT_W'(1);
        if (bit_cnt == '0) begin
          state_next = ST_REM_PUSH;
        end
      end
      ST_REM_PUSH: begin
        push_data  = rem;
        push_en    = stack_room;
        if (stack_room) begin
          cnt_next = cnt + CNT_W'(1);
        end
        state_next = ST_CHECK;
      end
      ST_POP_RD: begin
        rd_en      = 1'b1;
        cnt_next   = cnt_dec;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (cnt == '0) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_POP_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy         = state != ST_IDLE;
  assign digit_strobe = state == ST_EMIT;
  assign digit_value  = rd_data;
  assign digit_char   = ascii_of(rd_data);
  assign last_digit   = (state == ST_EMIT) && (cnt == '0);

endmodule

// File: hdl/rdc_checker.sv
module rdc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          digit_strobe,
  input logic [rdc_pkg::DIGIT_W-1:0]    digit_value,
  input logic [rdc_pkg::CHAR_W-1:0]     digit_char,
  input logic                          last_digit
);
  import rdc_pkg::*;

  // a word is taken only when idle, and the unit is busy right after
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("unit not busy after accepting a word");

  // results come only while a word is in work
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    digit_strobe |-> busy)
    else $error("result word while idle");

  // the last digit ends the run
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (digit_strobe && last_digit) |=> !busy)
    else $error("unit still busy after last digit");

  // last flag only with a strobe
  a_last_strobed: assert property (@(posedge clk) disable iff (rst)
    last_digit |-> digit_strobe)
    else $error("last flag without a result word");

  // character matches the digit value
  a_char_map: assert property (@(posedge clk) disable iff (rst)
    digit_strobe |->
      ((digit_value < DEC_LIMIT) && (digit_char == CHAR_W'(digit_value) + CHAR_ZERO)) ||
      ((digit_value >= DEC_LIMIT) && (digit_char == CHAR_W'(digit_value) + CHAR_ALPHA)))
    else $error("digit character does not match digit value");

endmodule

bind radix_digit_converter_unit rdc_checker u_rdc_checker (.*);

// File: sim/tb_radix_digit_converter_unit.sv
module tb_radix_digit_converter_unit;

  localparam int VW        = rdc_pkg::VALUE_BITS;
  localparam int DW        = rdc_pkg::DIGIT_W;
  localparam int CW        = rdc_pkg::CHAR_W;
  localparam int MAX_CYCLE = 3_000_000;
  localparam int DRAIN_PAD = 40;

  typedef struct packed {
    logic [DW-1:0] dval;
    logic [CW-1:0] dchar;
    logic          dlast;
  } digit_t;

  typedef struct {
    logic          set_rdx;
    logic [DW-1:0] rdx;
    logic [VW-1:0] v;
    string         want;
  } stim_row_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  logic          busy;
  logic [VW-1:0] value = '0;
  logic          radix_wr_en = 1'b0;
  logic [DW-1:0] radix_wr_data = '0;
  logic          digit_strobe;
  logic [DW-1:0] digit_value;
  logic [CW-1:0] digit_char;
  logic          last_digit;

  digit_t        pending_digits[$];
  stim_row_t     rows[$];
  logic [DW-1:0] radix_reg = rdc_pkg::RADIX_RESET;
  int            mismatch_count = 0;
  int            cycle_count = 0;
  bit            steady = 1'b0;

  radix_digit_converter_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .value         (value),
    .radix_wr_en   (radix_wr_en),
    .radix_wr_data (radix_wr_data),
    .digit_strobe  (digit_strobe),
    .digit_value   (digit_value),
    .digit_char    (digit_char),
    .last_digit    (last_digit)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLE) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic logic [31:0] base_of(input logic [DW-1:0] r);
    logic [31:0] b;
    b = 32'(r);
    if (b < 2) b = 2;
    if (b > 36) b = 36;
    return b;
  endfunction

  function automatic void predict_digits(input logic [VW-1:0] v);
    logic [31:0] b;
    logic [31:0] q;
    logic [DW-1:0] stack[$];
    digit_t d;
    b = base_of(radix_reg);
    q = 32'(v);
    while (q >= b) begin
      stack.push_back(DW'(q % b));
      q = q / b;
    end
    stack.push_back(DW'(q));
    for (int i = stack.size() - 1; i >= 0; i--) begin
      d.dval  = stack[i];
      d.dchar = (stack[i] < 10) ? CW'(stack[i]) + CW'(48) : CW'(stack[i]) + CW'(55);
      d.dlast = (i == 0);
      pending_digits.push_back(d);
    end
  endfunction

  function automatic void expect_text(input string want);
    digit_t d;
    for (int i = 0; i < want.len(); i++) begin
      d.dchar = CW'(want[i]);
      d.dval  = (want[i] < 8'd65) ? DW'(want[i] - 8'd48) : DW'(want[i] - 8'd55);
      d.dlast = (i == want.len() - 1);
      pending_digits.push_back(d);
    end
  endfunction

  function automatic void add_row(input logic s, input logic [DW-1:0] r,
                                  input logic [VW-1:0] v, input string want);
    stim_row_t row;
    row.set_rdx = s;
    row.rdx     = r;
    row.v       = v;
    row.want    = want;
    rows.push_back(row);
  endfunction

  always @(posedge clk) begin
    digit_t e;
    if (!rst && digit_strobe) begin
      if (pending_digits.size() == 0) begin
        flag_mismatch($sformatf("unexpected digit %0d", digit_value));
      end else begin
        e = pending_digits.pop_front();
        if (digit_value !== e.dval)
          flag_mismatch($sformatf("digit_value %0d, want %0d", digit_value, e.dval));
        if (digit_char !== e.dchar)
          flag_mismatch($sformatf("digit_char %0d, want %0d", digit_char, e.dchar));
        if (last_digit !== e.dlast)
          flag_mismatch($sformatf("last_digit %0b, want %0b", last_digit, e.dlast));
      end
    end
  end

  task automatic send_word(input logic [VW-1:0] v, input string want);
    int gap;
    @(negedge clk);
    if (!steady && $urandom_range(0, 99) < 27) begin
      start <= 1'b0;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 300) : $urandom_range(1, 12);
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    value <= v;
    do @(posedge clk); while (busy);
    if (want == "") predict_digits(v);
    else expect_text(want);
  endtask

  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (pending_digits.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic set_radix(input logic [DW-1:0] r);
    drain();
    radix_wr_en   <= 1'b1;
    radix_wr_data <= r;
    radix_reg      = r;
    @(negedge clk);
    radix_wr_en <= 1'b0;
  endtask

  initial begin
    logic [VW-1:0] v;
    logic [31:0]   b;
    longint        p;
    int            reps;

    // values first under the reset radix
    add_row(1'b0, '0, 31'd0, "0");
    add_row(1'b0, '0, 31'd9, "9");
    add_row(1'b0, '0, 31'd10, "10");
    add_row(1'b0, '0, 31'h7FFF_FFFF, "2147483647");
    add_row(1'b0, '0, 31'd1234567890, "");
    add_row(1'b1, 6'd16, 31'h7FFF_FFFF, "7FFFFFFF");
    add_row(1'b0, '0, 31'h00AB_CDEF, "ABCDEF");
    add_row(1'b0, '0, 31'd15, "F");
    add_row(1'b1, 6'd2, 31'h7FFF_FFFF, "1111111111111111111111111111111");
    add_row(1'b0, '0, 31'd1, "1");
    add_row(1'b0, '0, 31'h2AAA_AAAA, "");
    add_row(1'b1, 6'd36, 31'h7FFF_FFFF, "ZIK0ZJ");
    add_row(1'b0, '0, 31'd35, "Z");
    add_row(1'b0, '0, 31'd36, "10");
    add_row(1'b0, '0, 31'd1295, "ZZ");
    // out-of-range radix saturates
    add_row(1'b1, 6'd0, 31'd5, "101");
    add_row(1'b1, 6'd1, 31'd2, "10");
    add_row(1'b1, 6'd37, 31'd36, "10");
    add_row(1'b1, 6'd63, 31'd35, "Z");
    add_row(1'b0, '0, 31'd1000000, "");
    add_row(1'b1, 6'd7, 31'd0, "0");
    add_row(1'b0, '0, 31'd48, "66");
    add_row(1'b1, 6'd10, 31'd99, "99");

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].set_rdx) set_radix(rows[i].rdx);
      send_word(rows[i].v, rows[i].want);
    end

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_radix(6'd2);
        1: set_radix(6'd36);
        2: set_radix(6'd0);
        3: set_radix(6'd63);
        default: set_radix(DW'($urandom_range(0, 63)));
      endcase
      steady = (ph == 5);
      b = base_of(radix_reg);
      for (int k = 0; k < 25; k++) begin
        case ($urandom_range(0, 4))
          0: v = VW'($urandom);
          1: v = VW'($urandom_range(0, 1000));
          2: v = VW'($urandom) >> $urandom_range(0, VW - 1);
          3: begin
            p = 1;
            reps = $urandom_range(1, 8);
            for (int j = 0; j < reps && p * b < 64'h7FFF_FFFF; j++) p = p * b;
            v = VW'(p - $urandom_range(0, 1));
          end
          default: v = 31'h7FFF_FFFF - VW'($urandom_range(0, 1000));
        endcase
        send_word(v, "");
      end
    end
    steady = 1'b0;

    drain();
    repeat (DRAIN_PAD) @(posedge clk);
    if (mismatch_count == 0 && pending_digits.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/rdc_pkg.sv
hdl/radix_digit_converter_unit.sv
hdl/rdc_checker.sv
sim/tb_radix_digit_converter_unit.sv
